// File: rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and calendar functions
// Day numbers count from 0000-01-01; leap years follow the 4/100/400 rule.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 23;
    localparam int CNT_W   = 22;
    localparam int NUM_W   = 22;
    localparam int SUM_W   = OFF_W + 2;
    localparam int IN_W    = 2 * (YEAR_W + MONTH_W + DAY_W) + OFF_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = YEAR_W + MONTH_W + DAY_W + CNT_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DIFF = 1'b1;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    // days in years 0..9999
    localparam logic [NUM_W-1:0] DAYS_TOTAL = 22'd3652425;

    // x / 100 as (x * 5243) >> 19, exact for x below 43699
    localparam int          DIV_W     = 29;
    localparam int          DIV_SHIFT = 19;
    localparam logic [12:0] RECIP100  = 13'd5243;

    // year estimate n / 365.2425 as (n * 2939806) >> 30
    localparam int          EST_W      = 44;
    localparam int          YEAR_SHIFT = 30;
    localparam logic [21:0] YEAR_RECIP = 22'd2939806;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic [YEAR_W:0] div100(input logic [YEAR_W:0] x);
        logic [DIV_W-1:0] p;
        begin
            p = DIV_W'(x) * DIV_W'(RECIP100);
            div100 = (YEAR_W+1)'(p >> DIV_SHIFT);
        end
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] q100;
        logic [6:0]        r100;
        begin
            q100 = YEAR_W'(div100({1'b0, y}));
            r100 = 7'(y - YEAR_W'(q100 * 100));
            is_leap = (y[1:0] == 2'd0 && r100 != 7'd0) ||
                      (r100 == 7'd0 && q100[1:0] == 2'd0);
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            default: month_len = 5'd0;
        endcase
    endfunction

    // days before month m of a common year
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        case (m)
            4'd1:    cum_days = 9'd0;
            4'd2:    cum_days = 9'd31;
            4'd3:    cum_days = 9'd59;
            4'd4:    cum_days = 9'd90;
            4'd5:    cum_days = 9'd120;
            4'd6:    cum_days = 9'd151;
            4'd7:    cum_days = 9'd181;
            4'd8:    cum_days = 9'd212;
            4'd9:    cum_days = 9'd243;
            4'd10:   cum_days = 9'd273;
            4'd11:   cum_days = 9'd304;
            4'd12:   cum_days = 9'd334;
            default: cum_days = 9'd0;
        endcase
    endfunction

    // days in years 0..y-1
    function automatic logic [NUM_W-1:0] days_before_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W:0] y1;
        begin
            y1 = {1'b0, y};
            days_before_year = NUM_W'(y1 * 365) + NUM_W'((y1 + 3) >> 2)
                             - NUM_W'(div100(y1 + 15'd99))
                             + NUM_W'(div100(y1 + 15'd399) >> 2);
        end
    endfunction

    function automatic logic date_valid(input date_t dt);
        date_valid = dt.year <= YEAR_MAX && dt.day != 5'd0 &&
                     dt.day <= month_len(dt.month, is_leap(dt.year));
    endfunction

endpackage

// File: rtl/gda_to_num.sv
// ----------------------------------------------------------------------------
// gda_to_num: date to day number, two register stages
// Stage 1 checks the dates and forms year and month bases; stage 2 sums.
// ----------------------------------------------------------------------------
module gda_to_num (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic                 in_op,
    input  gda_pkg::date_t       in_a,
    input  gda_pkg::date_t       in_b,
    input  logic [gda_pkg::OFF_W-1:0] in_offset,
    output logic                 out_valid,
    output logic                 out_op,
    output logic                 out_err,
    output logic [gda_pkg::NUM_W-1:0] out_na,
    output logic [gda_pkg::NUM_W-1:0] out_nb,
    output logic [gda_pkg::OFF_W-1:0] out_offset
);
    import gda_pkg::*;

    logic              v1_reg, op1_reg, err1_reg;
    logic [NUM_W-1:0]  ya_reg, yb_reg;
    logic [9:0]        da_reg, db_reg;
    logic [OFF_W-1:0]  off1_reg;
    logic              v2_reg, op2_reg, err2_reg;
    logic [NUM_W-1:0]  na_reg, nb_reg;
    logic [OFF_W-1:0]  off2_reg;
    logic              err1_next;

    function automatic logic [9:0] day_of_year(input date_t dt);
        day_of_year = 10'(cum_days(dt.month)) + 10'(dt.day) - 10'd1 +
                      ((is_leap(dt.year) && dt.month > 4'd2) ? 10'd1 : 10'd0);
    endfunction

    assign err1_next = !date_valid(in_a) || (in_op == OP_DIFF && !date_valid(in_b));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= in_op;
            err1_reg <= err1_next;
            ya_reg   <= days_before_year(in_a.year);
            yb_reg   <= days_before_year(in_b.year);
            da_reg   <= day_of_year(in_a);
            db_reg   <= day_of_year(in_b);
            off1_reg <= in_offset;
            op2_reg  <= op1_reg;
            err2_reg <= err1_reg;
            na_reg   <= ya_reg + NUM_W'(da_reg);
            nb_reg   <= yb_reg + NUM_W'(db_reg);
            off2_reg <= off1_reg;
        end
    end

    assign out_valid  = v2_reg;
    assign out_op     = op2_reg;
    assign out_err    = err2_reg;
    assign out_na     = na_reg;
    assign out_nb     = nb_reg;
    assign out_offset = off2_reg;
endmodule

// File: rtl/gda_to_date.sv
// ----------------------------------------------------------------------------
// gda_to_date: offset add and day number to date, four register stages
// Stage 1 adds and takes the day difference, stage 2 estimates the year,
// stage 3 fixes it, stage 4 splits the day of year into month and day.
// ----------------------------------------------------------------------------
module gda_to_date (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic                 in_op,
    input  logic                 in_err,
    input  logic [gda_pkg::NUM_W-1:0] in_na,
    input  logic [gda_pkg::NUM_W-1:0] in_nb,
    input  logic [gda_pkg::OFF_W-1:0] in_offset,
    output logic                 out_valid,
    output gda_pkg::date_t       out_date,
    output logic [gda_pkg::CNT_W-1:0] out_count,
    output logic                 out_err
);
    import gda_pkg::*;

    logic             v_reg [4];
    logic             op_reg [4];
    logic             err_reg [4];
    logic [NUM_W-1:0] n1_reg, n2_reg;
    logic [CNT_W-1:0] cnt1_reg, cnt2_reg, cnt3_reg, cnt4_reg;
    logic [YEAR_W-1:0] y2_reg, y3_reg;
    logic [8:0]       r3_reg;
    date_t            d4_reg;

    logic signed [SUM_W-1:0] sum;
    logic             range_err;
    logic [YEAR_W-1:0] y_est;
    logic [NUM_W-1:0] base0, base1;
    logic [YEAR_W-1:0] y_fix;
    logic [NUM_W-1:0] rem_full;
    logic             leap3;
    logic [MONTH_W-1:0] m_sel;
    logic [8:0]       adj_cum;

    assign sum = SUM_W'(signed'({1'b0, in_na})) + SUM_W'(signed'(in_offset));
    assign range_err = sum < 0 || sum >= SUM_W'(signed'({1'b0, DAYS_TOTAL}));

    // year estimate by n/365.2425, within one year of the true year
    assign y_est = YEAR_W'((EST_W'(n1_reg) * EST_W'(YEAR_RECIP)) >> YEAR_SHIFT);

    always_comb
    begin
        base0 = days_before_year(y2_reg);
        base1 = days_before_year(y2_reg + 14'd1);
        if (base0 > n2_reg)
        begin
            y_fix    = y2_reg - 14'd1;
            rem_full = n2_reg - days_before_year(y2_reg - 14'd1);
        end
        else if (y2_reg < YEAR_MAX && base1 <= n2_reg)
        begin
            y_fix    = y2_reg + 14'd1;
            rem_full = n2_reg - base1;
        end
        else
        begin
            y_fix    = y2_reg;
            rem_full = n2_reg - base0;
        end
    end

    always_comb
    begin
        leap3 = is_leap(y3_reg);
        m_sel = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (r3_reg >= cum_days(MONTH_W'(k)) +
                ((leap3 && k > 2) ? 9'd1 : 9'd0))
                m_sel = MONTH_W'(k);
        end
        adj_cum = cum_days(m_sel) + ((leap3 && m_sel > 4'd2) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]  <= in_op;
            err_reg[0] <= in_err || (in_op == OP_ADD && range_err);
            n1_reg     <= NUM_W'(sum);
            cnt1_reg   <= (in_na > in_nb) ? in_na - in_nb : in_nb - in_na;
            for (int i = 1; i < 4; i++)
            begin
                op_reg[i]  <= op_reg[i-1];
                err_reg[i] <= err_reg[i-1];
            end
            n2_reg   <= n1_reg;
            y2_reg   <= (y_est > YEAR_MAX) ? YEAR_MAX : y_est;
            cnt2_reg <= cnt1_reg;
            y3_reg   <= y_fix;
            r3_reg   <= 9'(rem_full);
            cnt3_reg <= cnt2_reg;
            d4_reg.year  <= y3_reg;
            d4_reg.month <= m_sel;
            d4_reg.day   <= DAY_W'(r3_reg - adj_cum + 9'd1);
            cnt4_reg <= cnt3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign out_err   = err_reg[3];
    assign out_date  = (err_reg[3] || op_reg[3] == OP_DIFF) ? '0 : d4_reg;
    assign out_count = (err_reg[3] || op_reg[3] == OP_ADD) ? '0 : cnt4_reg;
endmodule

// File: rtl/gregorian_date_add_and_difference.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_and_difference: Gregorian date add and day difference
// Adds a signed day offset to a date, or gives the days between two dates.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: op; tdata: date A, offset,
//                                        date B
// m_axis    out  m_axis_tvalid/tready    tuser: error; tdata: year_out,
//                                        month_out, day_out, day_count
//
// Six-stage pipeline plus an output register; one request can enter every
// cycle unless the output stalls.
// The whole pipeline advances only when the output register is free or
// being drained, so a stall holds every stage in place.
// Reset clears the stage valid bits and the output valid.
// ----------------------------------------------------------------------------
module gregorian_date_add_and_difference (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // year_a, month_a, day_a, offset, year_b, month_b, day_b, zero fill
    input  logic [gda_pkg::IN_BYTES_W-1:0] s_axis_tdata,
    // op
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // year_out, month_out, day_out, day_count, zero fill
    output logic [gda_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
    // error
    output logic m_axis_tuser
);
    import gda_pkg::*;

    logic             en;
    date_t            a, b;
    logic             op;
    logic [OFF_W-1:0] offset;
    logic             v_n, op_n, err_n;
    logic [NUM_W-1:0] na, nb;
    logic [OFF_W-1:0] off_n;
    logic             v_d, err_d;
    date_t            d_d;
    logic [CNT_W-1:0] cnt_d;
    logic             out_valid_reg;
    logic             out_err_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign op     = s_axis_tuser;
    assign a      = {s_axis_tdata[13:0], s_axis_tdata[17:14], s_axis_tdata[22:18]};
    assign offset = s_axis_tdata[45:23];
    assign b      = {s_axis_tdata[59:46], s_axis_tdata[63:60], s_axis_tdata[68:64]};

    gda_to_num u_to_num (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid), .in_op(op), .in_a(a), .in_b(b), .in_offset(offset),
        .out_valid(v_n), .out_op(op_n), .out_err(err_n),
        .out_na(na), .out_nb(nb), .out_offset(off_n)
    );

    gda_to_date u_to_date (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v_n), .in_op(op_n), .in_err(err_n),
        .in_na(na), .in_nb(nb), .in_offset(off_n),
        .out_valid(v_d), .out_date(d_d), .out_count(cnt_d), .out_err(err_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_d;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {cnt_d, d_d.day, d_d.month, d_d.year};
            out_err_reg  <= err_d;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BYTES_W'(out_data_reg);
    assign m_axis_tuser  = out_err_reg;
endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: date add and day difference checker
// Drives random and corner-case requests into the stream input, predicts each
// result with an independent calendar model and compares every output field.
// ----------------------------------------------------------------------------
module testbench;
    import gda_pkg::*;

    // request: {tdata payload, op}; result: {error, tdata payload}
    localparam int IN_PAY_W  = IN_W + 1;
    localparam int OUT_PAY_W = OUT_W + 1;
    localparam int LIMIT     = 400000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_BYTES_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [IN_PAY_W-1:0]  request_q[$];
    logic [OUT_PAY_W-1:0] expected_q[$];
    int mismatches;
    int cycles;
    int gap_left;
    int burst_left;

    gregorian_date_add_and_difference DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int y, int m);
        int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && leap_year(y))
            return 29;
        return lens[m];
    endfunction

    function automatic int year_start(int y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic bit good_date(int y, int m, int d);
        return y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m);
    endfunction

    function automatic int day_number(int y, int m, int d);
        int n;
        n = year_start(y);
        for (int k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d - 1;
    endfunction

    function automatic logic [OUT_PAY_W-1:0] calendar_result(logic [IN_PAY_W-1:0] req);
        logic                op;
        int                  ya, ma, da, yb, mb, db, n, yy, mm, rem, span;
        logic [OFF_W-1:0]    off;
        logic [YEAR_W-1:0]   yo;
        logic [MONTH_W-1:0]  mo;
        logic [DAY_W-1:0]    dout;
        logic [CNT_W-1:0]    cnt;
        logic                err;
        op  = req[0];
        ya  = int'(req[1 +: YEAR_W]);
        ma  = int'(req[15 +: MONTH_W]);
        da  = int'(req[19 +: DAY_W]);
        off = req[24 +: OFF_W];
        yb  = int'(req[47 +: YEAR_W]);
        mb  = int'(req[61 +: MONTH_W]);
        db  = int'(req[65 +: DAY_W]);
        yo = '0; mo = '0; dout = '0; cnt = '0; err = 1'b0;
        if (op == OP_ADD) begin
            if (!good_date(ya, ma, da))
                err = 1'b1;
            else begin
                n = day_number(ya, ma, da) + $signed(off);
                if (n < 0 || n >= year_start(10000))
                    err = 1'b1;
                else begin
                    yy = 0;
                    while (yy < 9999 && year_start(yy + 1) <= n)
                        yy += (year_start(yy + 400) <= n && yy + 400 <= 9999) ? 400 : 1;
                    rem = n - year_start(yy);
                    mm = 1;
                    while (mm < 12 && rem >= month_days(yy, mm)) begin
                        rem -= month_days(yy, mm);
                        mm++;
                    end
                    yo = YEAR_W'(yy); mo = MONTH_W'(mm); dout = DAY_W'(rem + 1);
                end
            end
        end else begin
            if (!good_date(ya, ma, da) || !good_date(yb, mb, db))
                err = 1'b1;
            else begin
                span = day_number(ya, ma, da) - day_number(yb, mb, db);
                cnt = CNT_W'((span < 0) ? -span : span);
            end
        end
        return {err, cnt, dout, mo, yo};
    endfunction

    function automatic logic [IN_PAY_W-1:0] pack_request(logic op, int ya, int ma, int da,
                                                         int off, int yb, int mb, int db);
        return {5'(db), 4'(mb), 14'(yb), 23'(off), 5'(da), 4'(ma), 14'(ya), op};
    endfunction

    function automatic int rand_year();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(9996, 9999);
            2:       return $urandom_range(0, 16383);
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    task automatic queue_request(logic op, int ya, int ma, int da, int off,
                                 int yb, int mb, int db);
        request_q.push_back(pack_request(op, ya, ma, da, off, yb, mb, db));
    endtask

    task automatic report(string what, logic [OUT_PAY_W-1:0] got, logic [OUT_PAY_W-1:0] want);
        $display("error: %s got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    initial
    begin
        int ya, ma, da, yb, mb, db, off;
        logic op;
        // extremes, leap rules, range edges, invalid dates
        queue_request(OP_ADD, 0, 1, 1, 0, 0, 0, 0);
        queue_request(OP_ADD, 0, 1, 1, -1, 0, 0, 0);
        queue_request(OP_ADD, 9999, 12, 31, 1, 0, 0, 0);
        queue_request(OP_ADD, 9999, 12, 31, -3652424, 0, 0, 0);
        queue_request(OP_ADD, 0, 1, 1, 3652424, 0, 0, 0);
        queue_request(OP_ADD, 0, 1, 1, 4194303, 16383, 15, 31);
        queue_request(OP_ADD, 9999, 12, 31, -4194304, 16383, 15, 31);
        queue_request(OP_ADD, 2000, 2, 28, 1, 0, 0, 0);
        queue_request(OP_ADD, 1900, 2, 28, 1, 0, 0, 0);
        queue_request(OP_ADD, 2004, 3, 1, -1, 0, 0, 0);
        queue_request(OP_ADD, 1900, 2, 29, 0, 0, 0, 0);
        queue_request(OP_ADD, 10000, 1, 1, 0, 0, 0, 0);
        queue_request(OP_ADD, 16383, 15, 31, 0, 0, 0, 0);
        queue_request(OP_ADD, 5, 0, 1, 0, 0, 0, 0);
        queue_request(OP_ADD, 5, 13, 1, 0, 0, 0, 0);
        queue_request(OP_ADD, 5, 4, 31, 0, 0, 0, 0);
        queue_request(OP_ADD, 5, 4, 0, 0, 0, 0, 0);
        queue_request(OP_DIFF, 0, 1, 1, 0, 9999, 12, 31);
        queue_request(OP_DIFF, 9999, 12, 31, 4194303, 0, 1, 1);
        queue_request(OP_DIFF, 2024, 2, 29, -1, 2024, 2, 29);
        queue_request(OP_DIFF, 2023, 2, 29, 0, 2024, 1, 1);
        queue_request(OP_DIFF, 2023, 1, 1, 0, 2024, 6, 31);
        queue_request(OP_DIFF, 2023, 1, 1, 0, 10000, 1, 1);
        queue_request(OP_DIFF, 2023, 1, 1, 0, 2023, 15, 0);
        for (int i = 0; i < 450; i++) begin
            op = $urandom_range(0, 1);
            ya = rand_year();
            ma = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            da = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, month_days(ya, ma) > 0 ?
                                                                month_days(ya, ma) : 31);
            yb = rand_year();
            mb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            db = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, month_days(yb, mb) > 0 ?
                                                                month_days(yb, mb) : 31);
            case ($urandom_range(0, 3))
                0:       off = $urandom_range(0, 800) - 400;
                1:       off = $urandom_range(0, 80000) - 40000;
                default: off = $signed(23'($urandom()));
            endcase
            queue_request(op, ya, ma, da, off, yb, mb, db);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic [IN_PAY_W-1:0] req;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            gap_left      = 0;
            burst_left    = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(calendar_result({s_axis_tdata[IN_W-1:0], s_axis_tuser}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || request_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_BYTES_W'(req[IN_PAY_W-1:1]);
                    s_axis_tuser  <= req[0];
                    if (burst_left > 0)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: stall pattern and result checking
    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_PAY_W-1:0] want;
        logic [OUT_PAY_W-1:0] got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[OUT_W-1:0]};
                if (expected_q.size() == 0)
                    report("unexpected result", got, '0);
                else begin
                    want = expected_q.pop_front();
                    if (got[13:0] !== want[13:0])
                        report("year_out", got, want);
                    if (got[17:14] !== want[17:14])
                        report("month_out", got, want);
                    if (got[22:18] !== want[22:18])
                        report("day_out", got, want);
                    if (got[44:23] !== want[44:23])
                        report("day_count", got, want);
                    if (got[45] !== want[45])
                        report("error", got, want);
                end
            end
            case ((cycles / 300) % 3)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        @(posedge rst_n);
        while (request_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
